>>> rtl/arm_fk_pkg.sv
// shared constants, types and helpers for the two-link arm forward kinematics block
// no dependencies; used by arm_fk_cordic and the top level
`default_nettype none

package arm_fk_pkg;

    // defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // internal turn fraction, 2^32 is one full turn
    localparam int TURN_W = 32;

    // cordic x/y word, signed q30 with headroom
    localparam int UNIT_W = 34;

    // link length and result widths
    localparam int LEN_W = 16;
    localparam int OUT_W = 18;

    // length times unit product, and its width after the q30 shift
    localparam int PROD_W = UNIT_W + LEN_W + 1;
    localparam int SC_W   = PROD_W - 30;

    // cordic start value 1/K in q30, and 2*pi in q29
    localparam logic signed [UNIT_W-1:0] GAIN_INV_Q30 = UNIT_W'(652032874);
    localparam logic signed [TURN_W:0]   TWO_PI_Q29   = 33'sd3373259426;

    // rounding half for the q30 to output shift
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd536870912);

    // result limits
    localparam logic signed [SC_W-1:0] SC_MAX = SC_W'(131071);
    localparam logic signed [SC_W-1:0] SC_MIN = -SC_W'(131072);

    // configuration register indexes; other indexes are ignored
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_LINK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_LINK = 2'd1;

    // reset lengths, 5.0 and 3.0
    localparam logic [LEN_W-1:0] FIRST_LINK_RST  = 16'd1280;
    localparam logic [LEN_W-1:0] SECOND_LINK_RST = 16'd768;

    typedef logic signed [OUT_W-1:0] t_coord;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic [TURN_W-1:0] arc_angle(input int idx);
        logic [TURN_W-1:0] a;
        case (idx)
            0:       a = 32'd536870912;
            1:       a = 32'd316933406;
            2:       a = 32'd167458907;
            3:       a = 32'd85004756;
            4:       a = 32'd42667331;
            5:       a = 32'd21354465;
            6:       a = 32'd10679838;
            7:       a = 32'd5340245;
            8:       a = 32'd2670163;
            9:       a = 32'd1335087;
            10:      a = 32'd667544;
            11:      a = 32'd333772;
            12:      a = 32'd166886;
            13:      a = 32'd83443;
            14:      a = 32'd41722;
            15:      a = 32'd20861;
            16:      a = 32'd10430;
            17:      a = 32'd5215;
            18:      a = 32'd2608;
            19:      a = 32'd1304;
            20:      a = 32'd652;
            21:      a = 32'd326;
            22:      a = 32'd163;
            23:      a = 32'd81;
            default: a = '0;
        endcase
        return a;
    endfunction

    // clamp to the signed result range
    function automatic t_coord sat_out(input logic signed [SC_W-1:0] v);
        logic signed [SC_W-1:0] c;
        if (v > SC_MAX) begin
            c = SC_MAX;
        end else if (v < SC_MIN) begin
            c = SC_MIN;
        end else begin
            c = v;
        end
        return c[OUT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/two_link_arm_forward_kinematics_unit.sv
// top level of the planar two-link arm forward kinematics block
// depends on arm_fk_pkg and arm_fk_cordic (one instance for the shoulder angle, one for the joint angle sum)
//
//  channel   direction  handshake                    word
//  input     in         i_valid / o_stall            shoulder and elbow angle
//  output    out        o_valid / i_stall            elbow, link two and tip vectors
//  config    in         i_cfg_valid / o_cfg_ready    register index and length
//
// the pipeline takes one word per cycle while the output is not stalled.
// the depth comes from the cordic chain: one micro-rotation per register stage.
// each stage holds its word until the next stage frees up; o_stall rises only
// when every stage holds a valid word and the output is stalled.
// synchronous reset clears the valid bits and reloads both link lengths.
`default_nettype none

module two_link_arm_forward_kinematics_unit
    import arm_fk_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // input channel
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [ANGLE_BITS-1:0]   i_shoulder_angle,
    input  wire logic [ANGLE_BITS-1:0]   i_elbow_angle,
    // output channel
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic signed [OUT_W-1:0]      o_elbow_x,
    output logic signed [OUT_W-1:0]      o_elbow_y,
    output logic signed [OUT_W-1:0]      o_link_two_x,
    output logic signed [OUT_W-1:0]      o_link_two_y,
    output logic signed [OUT_W-1:0]      o_tip_x,
    output logic signed [OUT_W-1:0]      o_tip_y,
    // configuration channel
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [LEN_W-1:0]        i_cfg_data
);

    localparam int PIPE_DEPTH = CORDIC_STAGES + 8;
    localparam int S_CORDIC   = CORDIC_STAGES + 4;
    localparam int S_SCALE    = CORDIC_STAGES + 5;
    localparam int S_ROUND    = CORDIC_STAGES + 6;
    localparam int S_OUT      = CORDIC_STAGES + 7;

    // link length registers
    logic [LEN_W-1:0] r_len1;
    logic [LEN_W-1:0] r_len2;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len1 <= FIRST_LINK_RST;
            r_len2 <= SECOND_LINK_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_FIRST_LINK:  r_len1 <= i_cfg_data;
                REG_SECOND_LINK: r_len2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // valid chain and per-stage advance
    logic [PIPE_DEPTH-1:0] r_vld;
    logic [PIPE_DEPTH-1:0] w_rdy;

    always_comb begin
        w_rdy[PIPE_DEPTH-1] = !r_vld[PIPE_DEPTH-1] || !i_stall;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // input register: shoulder angle and absolute link two angle
    logic [ANGLE_BITS-1:0] r_t1;
    logic [ANGLE_BITS-1:0] r_t12;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_t1  <= i_shoulder_angle;
            r_t12 <= i_shoulder_angle + i_elbow_angle;
        end
    end

    // unit vectors of both links
    logic signed [UNIT_W-1:0] w_cos1;
    logic signed [UNIT_W-1:0] w_sin1;
    logic signed [UNIT_W-1:0] w_cos2;
    logic signed [UNIT_W-1:0] w_sin2;

    arm_fk_cordic #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_link1 (
        .i_clk   (i_clk),
        .i_en    (w_rdy[S_CORDIC:1]),
        .i_angle (r_t1),
        .o_cos   (w_cos1),
        .o_sin   (w_sin1)
    );

    arm_fk_cordic #(
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic_link2 (
        .i_clk   (i_clk),
        .i_en    (w_rdy[S_CORDIC:1]),
        .i_angle (r_t12),
        .o_cos   (w_cos2),
        .o_sin   (w_sin2)
    );

    // scale by link length
    logic signed [PROD_W-1:0] r_pex;
    logic signed [PROD_W-1:0] r_pey;
    logic signed [PROD_W-1:0] r_plx;
    logic signed [PROD_W-1:0] r_ply;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_SCALE]) begin
            r_pex <= w_cos1 * $signed({1'b0, r_len1});
            r_pey <= w_sin1 * $signed({1'b0, r_len1});
            r_plx <= w_cos2 * $signed({1'b0, r_len2});
            r_ply <= w_sin2 * $signed({1'b0, r_len2});
        end
    end

    // round half up to the output format and clamp
    logic signed [PROD_W-1:0] w_rex;
    logic signed [PROD_W-1:0] w_rey;
    logic signed [PROD_W-1:0] w_rlx;
    logic signed [PROD_W-1:0] w_rly;
    t_coord                   r_ex;
    t_coord                   r_ey;
    t_coord                   r_lx;
    t_coord                   r_ly;

    assign w_rex = r_pex + ROUND_HALF;
    assign w_rey = r_pey + ROUND_HALF;
    assign w_rlx = r_plx + ROUND_HALF;
    assign w_rly = r_ply + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (w_rdy[S_ROUND]) begin
            r_ex <= sat_out(w_rex[PROD_W-1:30]);
            r_ey <= sat_out(w_rey[PROD_W-1:30]);
            r_lx <= sat_out(w_rlx[PROD_W-1:30]);
            r_ly <= sat_out(w_rly[PROD_W-1:30]);
        end
    end

    // output register with the tip sum
    always_ff @(posedge i_clk) begin
        if (w_rdy[S_OUT]) begin
            o_elbow_x    <= r_ex;
            o_elbow_y    <= r_ey;
            o_link_two_x <= r_lx;
            o_link_two_y <= r_ly;
            o_tip_x      <= sat_out(SC_W'(r_ex) + SC_W'(r_lx));
            o_tip_y      <= sat_out(SC_W'(r_ey) + SC_W'(r_ly));
        end
    end

    // stall only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld))
        else $error("input stalled while the pipeline has a free stage");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld[0])
        else $error("accepted word missing from the first stage");

    // tip is the clamped sum of the two vectors
    a_tip_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_tip_x == sat_out(SC_W'(o_elbow_x) + SC_W'(o_link_two_x)))
                  && (o_tip_y == sat_out(SC_W'(o_elbow_y) + SC_W'(o_link_two_y)))))
        else $error("tip does not match elbow plus link two");

endmodule

`default_nettype wire

>>> rtl/arm_fk_cordic.sv
// pipelined cordic rotation giving cos and sin (q30) of a binary angle
// depends on arm_fk_pkg; stage enables come from the top-level valid chain
`default_nettype none

module arm_fk_cordic
    import arm_fk_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic [CORDIC_STAGES+3:0]        i_en,
    input  wire logic [ANGLE_BITS-1:0]           i_angle,
    output logic signed [UNIT_W-1:0]             o_cos,
    output logic signed [UNIT_W-1:0]             o_sin
);

    // residual angle width, bounded by the last arc step
    localparam int ZR_W  = UNIT_W - CORDIC_STAGES;
    localparam int PZ_W  = ZR_W + TURN_W + 1;
    localparam int ZQ_W  = ZR_W + 2;
    localparam int PC_W  = UNIT_W + ZQ_W;
    localparam int COR_W = PC_W - 30;

    localparam int S_RES = CORDIC_STAGES + 1;
    localparam int S_MUL = CORDIC_STAGES + 2;
    localparam int S_FIN = CORDIC_STAGES + 3;

    logic signed [UNIT_W-1:0] r_x [0:CORDIC_STAGES];
    logic signed [UNIT_W-1:0] r_y [0:CORDIC_STAGES];
    logic signed [UNIT_W-1:0] r_z [0:CORDIC_STAGES];
    logic                     r_flip [0:CORDIC_STAGES];

    logic [TURN_W-1:0]        w_turn;
    logic                     w_flip;
    logic signed [TURN_W-1:0] w_zt;

    // angle reduction: fold the left half plane by a half turn
    assign w_turn = {i_angle, {(TURN_W-ANGLE_BITS){1'b0}}};
    assign w_flip = w_turn[TURN_W-1] ^ w_turn[TURN_W-2];
    assign w_zt   = {w_turn[TURN_W-1] ^ w_flip, w_turn[TURN_W-2:0]};

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= GAIN_INV_Q30;
            r_y[0]    <= '0;
            r_z[0]    <= UNIT_W'(w_zt);
            r_flip[0] <= w_flip;
        end
    end

    // rotation stages, one micro-rotation per register
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i_en[i+1]) begin
                if (!r_z[i][UNIT_W-1]) begin
                    r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] - UNIT_W'(arc_angle(i));
                end else begin
                    r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                    r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                    r_z[i+1] <= r_z[i] + UNIT_W'(arc_angle(i));
                end
                r_flip[i+1] <= r_flip[i];
            end
        end
    end

    // residual angle to radians in q30
    logic signed [PZ_W-1:0]   w_pz;
    logic signed [ZQ_W-1:0]   r_zr;
    logic signed [UNIT_W-1:0] r_xr;
    logic signed [UNIT_W-1:0] r_yr;
    logic                     r_fr;

    assign w_pz = $signed(r_z[CORDIC_STAGES][ZR_W-1:0]) * TWO_PI_Q29;

    always_ff @(posedge i_clk) begin
        if (i_en[S_RES]) begin
            r_zr <= w_pz[PZ_W-1:31];
            r_xr <= r_x[CORDIC_STAGES];
            r_yr <= r_y[CORDIC_STAGES];
            r_fr <= r_flip[CORDIC_STAGES];
        end
    end

    // first-order correction products
    logic signed [PC_W-1:0]   r_pxz;
    logic signed [PC_W-1:0]   r_pyz;
    logic signed [UNIT_W-1:0] r_xc;
    logic signed [UNIT_W-1:0] r_yc;
    logic                     r_fc;

    always_ff @(posedge i_clk) begin
        if (i_en[S_MUL]) begin
            r_pxz <= r_xr * r_zr;
            r_pyz <= r_yr * r_zr;
            r_xc  <= r_xr;
            r_yc  <= r_yr;
            r_fc  <= r_fr;
        end
    end

    // apply correction and undo the half-turn fold
    logic signed [COR_W-1:0]  w_cx;
    logic signed [COR_W-1:0]  w_cy;
    logic signed [UNIT_W-1:0] w_nx;
    logic signed [UNIT_W-1:0] w_ny;

    assign w_cx = r_pxz[PC_W-1:30];
    assign w_cy = r_pyz[PC_W-1:30];
    assign w_nx = r_xc - UNIT_W'(w_cy);
    assign w_ny = r_yc + UNIT_W'(w_cx);

    always_ff @(posedge i_clk) begin
        if (i_en[S_FIN]) begin
            o_cos <= r_fc ? -w_nx : w_nx;
            o_sin <= r_fc ? -w_ny : w_ny;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_two_link_arm_forward_kinematics_unit.sv
// self-checking testbench for two_link_arm_forward_kinematics_unit
// predicts each pose with a bit-exact cordic model kept in this file; needs arm_fk_pkg

module tb_two_link_arm_forward_kinematics_unit
    import arm_fk_pkg::*;
();

    localparam int ANGLE_W     = ANGLE_BITS_DEF;
    localparam int ROTATIONS   = CORDIC_STAGES_DEF;
    localparam int LATENCY     = CORDIC_STAGES_DEF + 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 6;
    localparam int REPORT_MAX  = 10;

    // turn fractions, 2^32 is one full turn
    localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

    // cordic start value 1/K in q30, 2*pi in q29, half lsb of the q30 shift
    localparam longint CORDIC_START = 64'sd652032874;
    localparam longint TWO_PI_Q29   = 64'sd3373259426;
    localparam longint ROUND_Q30    = 64'sd536870912;
    localparam longint COORD_MAX    = 64'sd131071;
    localparam longint COORD_MIN    = -64'sd131072;

    typedef struct packed {
        t_coord elbow_x;
        t_coord elbow_y;
        t_coord link_two_x;
        t_coord link_two_y;
        t_coord tip_x;
        t_coord tip_y;
    } t_arm_pose;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [ANGLE_W-1:0]       i_shoulder_angle;
    logic [ANGLE_W-1:0]       i_elbow_angle;
    logic                     o_valid;
    logic                     i_stall;
    t_coord                   o_elbow_x;
    t_coord                   o_elbow_y;
    t_coord                   o_link_two_x;
    t_coord                   o_link_two_y;
    t_coord                   o_tip_x;
    t_coord                   o_tip_y;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [LEN_W-1:0]         i_cfg_data;

    // atan(2^-k) in turn units, one entry per micro-rotation
    longint atan_turns [0:15] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    // model copy of the link length registers
    longint first_len;
    longint second_len;

    t_arm_pose   expected_poses [$];
    int          fail_count  = 0;
    int unsigned cycle_count = 0;
    int          send_idle_pct;
    int          stall_pct;

    two_link_arm_forward_kinematics_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_shoulder_angle (i_shoulder_angle),
        .i_elbow_angle    (i_elbow_angle),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_elbow_x        (o_elbow_x),
        .o_elbow_y        (o_elbow_y),
        .o_link_two_x     (o_link_two_x),
        .o_link_two_y     (o_link_two_y),
        .o_tip_x          (o_tip_x),
        .o_tip_y          (o_tip_y),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_two_link_arm_forward_kinematics_unit failed");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // cos and sin in q30 of a 32-bit turn fraction
    function automatic void cordic_unit(input logic [31:0] turn, output longint cos_q30,
                                        output longint sin_q30);
        logic [31:0] t;
        logic        flip;
        longint      x, y, z, zr, dx, dy;
        t    = turn;
        flip = 1'b0;
        // fold the left half plane onto the right one
        if (t >= QUARTER_TURN && t < THREE_QUARTER_TURN) begin
            t    = t - HALF_TURN;
            flip = 1'b1;
        end
        z = longint'($signed(t));
        x = CORDIC_START;
        y = 0;
        for (int k = 0; k < ROTATIONS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_turns[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_turns[k];
            end
        end
        // first-order touch-up by the leftover angle in radians
        zr = (z * TWO_PI_Q29) >>> 31;
        cos_q30 = x - ((y * zr) >>> 30);
        sin_q30 = y + ((x * zr) >>> 30);
        if (flip) begin
            cos_q30 = -cos_q30;
            sin_q30 = -sin_q30;
        end
    endfunction

    // length times q30 unit, rounded half up to the output format
    function automatic longint scale_len(input longint unit, input longint len);
        return (unit * len + ROUND_Q30) >>> 30;
    endfunction

    function automatic longint clamp_coord(input longint v);
        if (v > COORD_MAX) begin
            return COORD_MAX;
        end
        if (v < COORD_MIN) begin
            return COORD_MIN;
        end
        return v;
    endfunction

    function automatic t_arm_pose predict_pose(input logic [ANGLE_W-1:0] shoulder,
                                               input logic [ANGLE_W-1:0] elbow);
        logic [31:0] t1, t2;
        longint      c1, s1, c2, s2, ex, ey, lx, ly;
        t_arm_pose   p;
        t1 = 32'(shoulder) << (32 - ANGLE_W);
        t2 = 32'(elbow) << (32 - ANGLE_W);
        cordic_unit(t1, c1, s1);
        cordic_unit(t1 + t2, c2, s2);
        ex = clamp_coord(scale_len(c1, first_len));
        ey = clamp_coord(scale_len(s1, first_len));
        lx = clamp_coord(scale_len(c2, second_len));
        ly = clamp_coord(scale_len(s2, second_len));
        p.elbow_x    = t_coord'(ex);
        p.elbow_y    = t_coord'(ey);
        p.link_two_x = t_coord'(lx);
        p.link_two_y = t_coord'(ly);
        p.tip_x      = t_coord'(clamp_coord(ex + lx));
        p.tip_y      = t_coord'(clamp_coord(ey + ly));
        return p;
    endfunction

    // random angle, often close to a quadrant edge
    function automatic logic [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 3) == 0) begin
            return ANGLE_W'($urandom_range(0, 3) * (1 << (ANGLE_W - 2))
                            + $urandom_range(0, 8) - 4);
        end
        return ANGLE_W'($urandom);
    endfunction

    task automatic check_coord(input string field, input t_coord want, input t_coord got);
        if (want !== got) begin
            fail_count++;
            if (fail_count <= REPORT_MAX) begin
                $display("mismatch %s: expected %0d, got %0d", field, want, got);
            end
        end
    endtask

    // pose checker
    always @(posedge i_clk) begin
        t_arm_pose want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_poses.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_MAX) begin
                    $display("pose word with no angles pending: tip (%0d, %0d)",
                             o_tip_x, o_tip_y);
                end
            end else begin
                want = expected_poses.pop_front();
                check_coord("elbow_x", want.elbow_x, o_elbow_x);
                check_coord("elbow_y", want.elbow_y, o_elbow_y);
                check_coord("link_two_x", want.link_two_x, o_link_two_x);
                check_coord("link_two_y", want.link_two_y, o_link_two_y);
                check_coord("tip_x", want.tip_x, o_tip_x);
                check_coord("tip_y", want.tip_y, o_tip_y);
            end
        end
    end

    // one angle word, with an occasional idle cycle in front
    task automatic send_angles(input logic [ANGLE_W-1:0] shoulder,
                               input logic [ANGLE_W-1:0] elbow);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_shoulder_angle <= shoulder;
        i_elbow_angle    <= elbow;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_poses.push_back(predict_pose(shoulder, elbow));
    endtask

    // stop sending and let the pipeline empty out
    task automatic drain_poses();
        i_valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // write both link lengths back to back, pipeline idle
    task automatic set_links(input logic [LEN_W-1:0] len_one, input logic [LEN_W-1:0] len_two);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_FIRST_LINK;
        i_cfg_data  <= len_one;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        first_len    = longint'(len_one);
        i_cfg_index <= REG_SECOND_LINK;
        i_cfg_data  <= len_two;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        second_len   = longint'(len_two);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_angles(input int count);
        logic [ANGLE_W-1:0] shoulder, elbow;
        repeat (count) begin
            shoulder = pick_angle();
            elbow    = pick_angle();
            // aim the joint angle sum at a quadrant edge or a wrap
            if ($urandom_range(0, 3) == 0) begin
                elbow = pick_angle() - shoulder;
            end
            send_angles(shoulder, elbow);
        end
        drain_poses();
    endtask

    // quadrant edges, wrap of the angle sum, reset lengths
    task automatic test_reset_lengths();
        send_angles(16'h0000, 16'h0000);
        send_angles(16'h4000, 16'h0000);
        send_angles(16'h3FFF, 16'h0001);
        send_angles(16'h4001, 16'h0000);
        send_angles(16'h8000, 16'h0000);
        send_angles(16'hBFFF, 16'h0000);
        send_angles(16'hC000, 16'h0000);
        send_angles(16'hC001, 16'hFFFF);
        send_angles(16'hFFFF, 16'hFFFF);
        send_angles(16'hC000, 16'h8000);
        send_angles(16'h2000, 16'h2000);
        send_angles(16'h5555, 16'hAAAA);
        send_angles(16'hAAAA, 16'h5555);
        drain_poses();
    endtask

    // longest links drive the tip to the edge of its range, then zero links
    task automatic test_extreme_lengths();
        set_links('1, '1);
        send_angles(16'h0000, 16'h0000);
        send_angles(16'h8000, 16'h0000);
        send_angles(16'h4000, 16'h0000);
        send_angles(16'hC000, 16'h0000);
        send_angles(16'h2000, 16'hE000);
        drain_poses();
        set_links('0, '0);
        send_angles(16'h1234, 16'h4321);
        send_angles(16'hFFFF, 16'h0001);
        drain_poses();
    endtask

    // one random phase per length setting
    task automatic test_mixed_lengths();
        set_links('0, '1);
        send_random_angles(270);
        set_links('1, '0);
        send_random_angles(270);
        set_links(16'd1, 16'd1);
        send_random_angles(270);
        repeat (3) begin
            set_links(LEN_W'($urandom), LEN_W'($urandom));
            send_random_angles(270);
        end
    endtask

    // full rate in both directions
    task automatic test_steady_flow();
        send_idle_pct = 0;
        stall_pct     = 0;
        set_links(LEN_W'($urandom), LEN_W'($urandom));
        send_random_angles(300);
        send_idle_pct = IDLE_PCT;
        stall_pct     = IDLE_PCT;
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_shoulder_angle <= '0;
        i_elbow_angle    <= '0;
        i_stall          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= REG_FIRST_LINK;
        i_cfg_data       <= '0;
        first_len         = longint'(FIRST_LINK_RST);
        second_len        = longint'(SECOND_LINK_RST);
        send_idle_pct     = IDLE_PCT;
        stall_pct         = IDLE_PCT;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_lengths();
        test_extreme_lengths();
        test_mixed_lengths();
        test_steady_flow();

        if (fail_count == 0 && expected_poses.size() == 0) begin
            $display("tb_two_link_arm_forward_kinematics_unit passed");
        end else begin
            $display("tb_two_link_arm_forward_kinematics_unit failed");
        end
        $finish;
    end

endmodule
